[rtl/ipr_pkg.sv]
package ipr_pkg;

    localparam int MAX_COLS = 2048;
    localparam int MAX_ROWS = 2048;

    // Widths fixed by the port list
    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int POS_W  = 11;
    localparam int CNT_W  = 23;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int DIM_W  = CFG_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 1'b1;

    // Result slots of one pixel, in raster order
    localparam int SLOT_ABOVE = 0;  // (r-1, c)
    localparam int SLOT_LEFT  = 1;  // (r, c-1), last row only
    localparam int SLOT_LAST  = 2;  // (r, c), last pixel of the frame
    localparam int NUM_SLOTS  = 3;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } frame_cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [NUM_SLOTS-1:0] vld;
        logic [NUM_SLOTS-1:0] keep;
    } bundle_t;

endpackage

[rtl/ipr_front.sv]
module ipr_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_accept,
    input  logic [ipr_pkg::PIX_W-1:0]  mask_value,
    input  ipr_pkg::frame_cfg_t        frame_cfg,
    output logic                       push,
    output ipr_pkg::bundle_t           push_data
);

    localparam int COL_W = ipr_pkg::COL_W;
    localparam int ROW_W = ipr_pkg::ROW_W;
    localparam int DIM_W = ipr_pkg::DIM_W;

    logic [DIM_W-1:0] rows_eff;
    logic [DIM_W-1:0] cols_eff;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [1:0]       recent_reg, recent_next;
    logic [1:0]       win_cur_reg, win_cur_next;
    logic             prev_up_reg;
    logic             fwd_reg;
    logic [1:0]       fwd_data_reg;
    logic [1:0]       rd_data_reg;
    logic [1:0]       line_mem [ipr_pkg::MAX_COLS];

    logic             cur;
    logic             last_col;
    logic             last_row;
    logic [COL_W-1:0] n1;
    logic [DIM_W-1:0] n1_inc;
    logic [COL_W-1:0] n2;
    logic [1:0]       wdata;
    logic [1:0]       win_nxt;
    logic             up0, left0, right0;
    logic             left1, left2;

    // Clamp the frame size to the supported range
    always_comb begin
        rows_eff = frame_cfg.rows;
        if (frame_cfg.rows < DIM_W'(2)) begin
            rows_eff = DIM_W'(2);
        end else if (frame_cfg.rows > DIM_W'(ipr_pkg::MAX_ROWS)) begin
            rows_eff = DIM_W'(ipr_pkg::MAX_ROWS);
        end
        cols_eff = frame_cfg.cols;
        if (frame_cfg.cols < DIM_W'(1)) begin
            cols_eff = DIM_W'(1);
        end else if (frame_cfg.cols > DIM_W'(ipr_pkg::MAX_COLS)) begin
            cols_eff = DIM_W'(ipr_pkg::MAX_COLS);
        end
    end

    assign cur      = !mask_value[ipr_pkg::PIX_W-1] && (mask_value != '0);
    assign last_col = (DIM_W'(col_reg) + DIM_W'(1)) >= cols_eff;
    assign last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= rows_eff;

    // Column of the next pixel and of the one after it
    assign n1     = last_col ? '0 : COL_W'(col_reg + COL_W'(1));
    assign n1_inc = DIM_W'(n1) + DIM_W'(1);
    assign n2     = (n1_inc >= cols_eff) ? '0 : n1_inc[COL_W-1:0];

    // Bit 0: newest row, bit 1: row before it
    assign wdata   = {win_cur_reg[0], cur};
    assign win_nxt = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            line_mem[col_reg] <= wdata;
            rd_data_reg       <= line_mem[n2];
            fwd_data_reg      <= wdata;
            prev_up_reg       <= win_cur_reg[0];
            win_cur_reg       <= win_cur_next;
        end
    end

    always_comb begin
        win_cur_next = (n1 == col_reg) ? wdata : win_nxt;

        up0    = (row_reg > ROW_W'(1)) && win_cur_reg[1];
        left0  = (col_reg != '0) && prev_up_reg;
        right0 = !last_col && win_nxt[0];
        left1  = (col_reg > COL_W'(1)) && recent_reg[1];
        left2  = (col_reg != '0) && recent_reg[0];

        push_data.row = row_reg;
        push_data.col = col_reg;
        push_data.vld[ipr_pkg::SLOT_ABOVE]  = (row_reg != '0);
        push_data.vld[ipr_pkg::SLOT_LEFT]   = last_row && (col_reg != '0);
        push_data.vld[ipr_pkg::SLOT_LAST]   = last_row && last_col;
        push_data.keep[ipr_pkg::SLOT_ABOVE] =
            win_cur_reg[0] && (up0 || cur || left0 || right0);
        push_data.keep[ipr_pkg::SLOT_LEFT]  =
            recent_reg[0] && (left1 || prev_up_reg || cur);
        push_data.keep[ipr_pkg::SLOT_LAST]  = cur && (left2 || win_cur_reg[0]);

        push = in_accept && (push_data.vld != '0);

        row_next    = row_reg;
        col_next    = col_reg;
        recent_next = recent_reg;
        if (in_accept) begin
            if (last_col) begin
                col_next    = '0;
                row_next    = last_row ? '0 : ROW_W'(row_reg + ROW_W'(1));
                recent_next = '0;
            end else begin
                col_next    = COL_W'(col_reg + COL_W'(1));
                recent_next = (col_reg == '0) ? {1'b0, cur} : {recent_reg[0], cur};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg    <= '0;
            col_reg    <= '0;
            recent_reg <= '0;
            fwd_reg    <= 1'b0;
        end else begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            recent_reg <= recent_next;
            if (in_accept) begin
                fwd_reg <= (n2 == col_reg);
            end
        end
    end

endmodule

[rtl/ipr_queue.sv]
module ipr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ipr_pkg::bundle_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output ipr_pkg::bundle_t  pop_data
);

    localparam int QPTR_W = ipr_pkg::QPTR_W;
    localparam int CNT_W  = QPTR_W + 1;

    ipr_pkg::bundle_t  slot_mem [ipr_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(ipr_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + CNT_W'(1));
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + QPTR_W'(1));
            end
            if (do_pop) begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + QPTR_W'(1));
            end
        end
    end

endmodule

[rtl/ipr_back.sv]
module ipr_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  ipr_pkg::bundle_t           q_data,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [ipr_pkg::POS_W-1:0]  m_out_row,
    output logic [ipr_pkg::POS_W-1:0]  m_out_col,
    output logic                       m_keep_pixel,
    output logic                       m_frame_done,
    output logic [ipr_pkg::CNT_W-1:0]  m_kept_count
);

    localparam int POS_W = ipr_pkg::POS_W;
    localparam int CNT_W = ipr_pkg::CNT_W;
    localparam int NS    = ipr_pkg::NUM_SLOTS;

    ipr_pkg::bundle_t  bnd_reg;
    logic [NS-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [POS_W-1:0]  m_row_reg, m_col_reg;
    logic              m_keep_reg, m_done_reg;
    logic [CNT_W-1:0]  m_cnt_reg;

    logic              out_load;
    logic [NS-1:0]     sel;
    logic [NS-1:0]     rem_after;
    logic [POS_W-1:0]  sel_row, sel_col;
    logic              sel_keep, sel_done;
    logic [CNT_W-1:0]  cnt_inc;

    // Hand out the remaining slots of the bundle in raster order
    always_comb begin
        sel      = '0;
        sel_row  = POS_W'(bnd_reg.row);
        sel_col  = POS_W'(bnd_reg.col);
        sel_keep = 1'b0;
        sel_done = 1'b0;
        if (rem_reg[ipr_pkg::SLOT_ABOVE]) begin
            sel[ipr_pkg::SLOT_ABOVE] = 1'b1;
            sel_row  = POS_W'(bnd_reg.row - 1'b1);
            sel_keep = bnd_reg.keep[ipr_pkg::SLOT_ABOVE];
        end else if (rem_reg[ipr_pkg::SLOT_LEFT]) begin
            sel[ipr_pkg::SLOT_LEFT] = 1'b1;
            sel_col  = POS_W'(bnd_reg.col - 1'b1);
            sel_keep = bnd_reg.keep[ipr_pkg::SLOT_LEFT];
        end else if (rem_reg[ipr_pkg::SLOT_LAST]) begin
            sel[ipr_pkg::SLOT_LAST] = 1'b1;
            sel_keep = bnd_reg.keep[ipr_pkg::SLOT_LAST];
            sel_done = 1'b1;
        end

        out_load  = (rem_reg != '0) && (!m_valid_reg || m_ready);
        rem_after = out_load ? (rem_reg & ~sel) : rem_reg;
        pop       = q_valid && (rem_after == '0);
        rem_next  = pop ? q_data.vld : rem_after;

        // Saturating running count
        cnt_inc = (sel_keep && (cnt_reg != ipr_pkg::COUNT_MAX))
                  ? CNT_W'(cnt_reg + CNT_W'(1)) : cnt_reg;
        cnt_next = cnt_reg;
        if (out_load) begin
            cnt_next = sel_done ? '0 : cnt_inc;
        end

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            bnd_reg <= q_data;
        end
        if (out_load) begin
            m_row_reg  <= sel_row;
            m_col_reg  <= sel_col;
            m_keep_reg <= sel_keep;
            m_done_reg <= sel_done;
            m_cnt_reg  <= cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rem_reg     <= rem_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_keep_pixel = m_keep_reg;
    assign m_frame_done = m_done_reg;
    assign m_kept_count = m_cnt_reg;

endmodule

[rtl/isolated_pixel_remover.sv]
// Isolated pixel remover for a binary mask streamed in raster order.
// Input channel s_*: one signed mask pixel per transfer; a pixel is set when > 0.
// Result channel m_*: one result per pixel with its row and column, a keep flag
// (set and with a set 4-neighbour inside the frame), a running kept count and
// frame_done on the last result of the frame. Results follow raster order.
// Configuration channel cfg_*: index 0 writes frame_rows, index 1 frame_cols; write
// only between frames. Out-of-range sizes are clamped to 2..2048 rows, 1..2048 cols.
// Timing: the result for pixel (r-1,c) forms when pixel (r,c) is accepted, then
// passes the queue, bundle and output registers. Rows 0..rows-2 of input run at
// one pixel per clock while m_ready stays high; the last row also yields left
// results, so the single output register paces that row. The line store (one
// write and one read per cycle, one entry per column) keeps the rest at that rate.
// A four-entry queue sits between the classifier and the output serializer; when
// m_ready is low the queue fills and s_ready drops once it is full.
// Reset clears the position counters, the kept count and all queued results; the
// line store needs no clearing, since row 0 rewrites every column it reads later.
module isolated_pixel_remover (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [ipr_pkg::PIX_W-1:0] s_mask_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ipr_pkg::POS_W-1:0]      m_out_row,
    output logic [ipr_pkg::POS_W-1:0]      m_out_col,
    output logic                           m_keep_pixel,
    output logic                           m_frame_done,
    output logic [ipr_pkg::CNT_W-1:0]      m_kept_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ipr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipr_pkg::CFG_W-1:0]      cfg_data
);

    logic [ipr_pkg::CFG_W-1:0] frame_rows_reg;
    logic [ipr_pkg::CFG_W-1:0] frame_cols_reg;
    ipr_pkg::frame_cfg_t       frame_cfg;
    logic                      in_accept;
    logic                      front_push;
    ipr_pkg::bundle_t          front_data;
    logic                      q_full;
    logic                      q_valid;
    logic                      q_pop;
    ipr_pkg::bundle_t          q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= ipr_pkg::CFG_W'(ipr_pkg::MAX_ROWS);
            frame_cols_reg <= ipr_pkg::CFG_W'(ipr_pkg::MAX_COLS);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ipr_pkg::CFG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                ipr_pkg::CFG_FRAME_COLS: frame_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign frame_cfg.rows = frame_rows_reg;
    assign frame_cfg.cols = frame_cols_reg;

    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    ipr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .mask_value (s_mask_value),
        .frame_cfg  (frame_cfg),
        .push       (front_push),
        .push_data  (front_data)
    );

    ipr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_data (front_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    ipr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_keep_pixel (m_keep_pixel),
        .m_frame_done (m_frame_done),
        .m_kept_count (m_kept_count)
    );

    // A classified pixel must always find room in the queue
    assert property (@(posedge aclk) disable iff (!aresetn) front_push |-> !q_full)
        else $error("queue push while full");

    // The last result of a frame never lies in row 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> (m_out_row != '0))
        else $error("frame_done on row 0");

    // Output register is empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A kept pixel never carries a zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_keep_pixel) |-> (m_kept_count != '0))
        else $error("kept pixel with zero count");

endmodule

[tb/ipr_result_checker.sv]
`timescale 1ns / 100ps

module ipr_result_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic signed [ipr_pkg::PIX_W-1:0] s_mask_value,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [ipr_pkg::POS_W-1:0]        m_out_row,
    input  logic [ipr_pkg::POS_W-1:0]        m_out_col,
    input  logic                             m_keep_pixel,
    input  logic                             m_frame_done,
    input  logic [ipr_pkg::CNT_W-1:0]        m_kept_count,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ipr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ipr_pkg::CFG_W-1:0]        cfg_data,
    output int                               mismatches,
    output int                               backlog
);

    localparam int PIX_W    = ipr_pkg::PIX_W;
    localparam int POS_W    = ipr_pkg::POS_W;
    localparam int CNT_W    = ipr_pkg::CNT_W;
    localparam int CFG_W    = ipr_pkg::CFG_W;
    localparam int MAX_COLS = ipr_pkg::MAX_COLS;
    localparam int MAX_ROWS = ipr_pkg::MAX_ROWS;

    typedef struct {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             keep;
        logic             done;
        logic [CNT_W-1:0] count;
    } pixel_result_t;

    pixel_result_t    due_results[$];

    // bit 0: newest row, bit 1: the row before it
    logic [1:0]       col_history [MAX_COLS];
    // bit 0: previous pixel of this row, bit 1: the one before
    logic [1:0]       row_recent;
    int               row_pos;
    int               col_pos;
    logic [CNT_W-1:0] kept_so_far;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input pixel_result_t want,
                               input logic [CNT_W-1:0] got, input logic [CNT_W-1:0] exp);
        if (got !== exp) begin
            report($sformatf("%s of pixel (%0d,%0d): got %0d, expected %0d",
                             name, want.row, want.col, got, exp));
        end
    endtask

    task automatic push_result(input int row, input int col, input logic keep,
                               input logic done);
        pixel_result_t res;
        if (keep && kept_so_far != ipr_pkg::COUNT_MAX) begin
            kept_so_far++;
        end
        res.row   = row[POS_W-1:0];
        res.col   = col[POS_W-1:0];
        res.keep  = keep;
        res.done  = done;
        res.count = kept_so_far;
        due_results.push_back(res);
    endtask

    task automatic classify_pixel(input logic signed [PIX_W-1:0] value);
        int         rows;
        int         cols;
        int         r;
        int         c;
        logic       cur;
        logic       last_col;
        logic       last_row;
        logic       frame_end;
        logic       nbr;
        logic [1:0] old;
        rows = (rows_reg < 2) ? 2 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
        cols = (cols_reg < 1) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
        r = row_pos;
        c = col_pos;
        cur = (value > 0);
        last_col = (c + 1 >= cols);
        last_row = (r + 1 >= rows);
        frame_end = last_row && last_col;
        old = col_history[c];
        col_history[c] = {old[0], cur};

        // decide the pixel one row up, now that its lower neighbor is known
        if (r >= 1) begin
            nbr = cur;
            if (r >= 2) nbr |= old[1];
            if (c >= 1) nbr |= col_history[c-1][1];
            if (!last_col) nbr |= col_history[c+1][0];
            push_result(r - 1, c, old[0] & nbr, 1'b0);
        end

        // last row has no row below: resolve it as it streams in
        if (last_row) begin
            if (c >= 1) begin
                nbr = cur | col_history[c-1][1];
                if (c >= 2) nbr |= row_recent[1];
                push_result(r, c - 1, row_recent[0] & nbr, 1'b0);
            end
            if (last_col) begin
                nbr = old[0];
                if (c >= 1) nbr |= row_recent[0];
                push_result(r, c, cur & nbr, 1'b1);
            end
        end

        row_recent = (c == 0) ? {1'b0, cur} : {row_recent[0], cur};

        if (frame_end) begin
            row_pos = 0;
            col_pos = 0;
            kept_so_far = '0;
            row_recent = '0;
        end else if (last_col) begin
            col_pos = 0;
            row_pos = r + 1;
            row_recent = '0;
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge aclk) begin
        pixel_result_t want;
        if (!aresetn) begin
            due_results.delete();
            foreach (col_history[i]) col_history[i] = '0;
            row_recent = '0;
            row_pos = 0;
            col_pos = 0;
            kept_so_far = '0;
            rows_reg = CFG_W'(MAX_ROWS);
            cols_reg = CFG_W'(MAX_COLS);
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ipr_pkg::CFG_FRAME_ROWS) begin
                    rows_reg = cfg_data;
                end else if (cfg_index == ipr_pkg::CFG_FRAME_COLS) begin
                    cols_reg = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                classify_pixel(s_mask_value);
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report($sformatf("result for (%0d,%0d) with nothing outstanding",
                                     m_out_row, m_out_col));
                end else begin
                    want = due_results.pop_front();
                    check_field("out_row", want, CNT_W'(m_out_row), CNT_W'(want.row));
                    check_field("out_col", want, CNT_W'(m_out_col), CNT_W'(want.col));
                    check_field("keep_pixel", want, CNT_W'(m_keep_pixel), CNT_W'(want.keep));
                    check_field("frame_done", want, CNT_W'(m_frame_done), CNT_W'(want.done));
                    check_field("kept_count", want, m_kept_count, want.count);
                end
            end
        end
        backlog = due_results.size();
    end

endmodule

[tb/isolated_pixel_remover_test.sv]
`timescale 1ns / 100ps

module isolated_pixel_remover_test;

    localparam int PIX_W     = ipr_pkg::PIX_W;
    localparam int POS_W     = ipr_pkg::POS_W;
    localparam int CNT_W     = ipr_pkg::CNT_W;
    localparam int CFG_W     = ipr_pkg::CFG_W;
    localparam int CFG_IDX_W = ipr_pkg::CFG_IDX_W;
    localparam int MAX_ROWS  = ipr_pkg::MAX_ROWS;
    localparam int MAX_COLS  = ipr_pkg::MAX_COLS;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_PCT      = 13;
    localparam int RANDOM_PIXELS = 220;

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    s_valid      = 1'b0;
    logic signed [PIX_W-1:0] s_mask_value = '0;
    logic                    m_ready      = 1'b0;
    logic                    cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index    = ipr_pkg::CFG_FRAME_ROWS;
    logic [CFG_W-1:0]        cfg_data     = '0;
    logic                    steady       = 1'b0;

    logic                    s_ready;
    logic                    m_valid;
    logic [POS_W-1:0]        m_out_row;
    logic [POS_W-1:0]        m_out_col;
    logic                    m_keep_pixel;
    logic                    m_frame_done;
    logic [CNT_W-1:0]        m_kept_count;
    logic                    cfg_ready;
    int                      mismatches;
    int                      backlog;
    int                      quiet_cycles = 0;
    int                      random_sent  = 0;

    // 3x4 frame: isolated corner, vertical pair on the right edge,
    // horizontal pair in the last row, field extremes throughout
    logic signed [PIX_W-1:0] pattern [12] = '{
        8'sd1,  8'sd0, 8'sd0,  8'sd127,
        8'sd0,  8'sd0, -8'sd1, 8'sd1,
        8'sd64, 8'sd2, 8'sd0,  -8'sd128
    };

    always #2 aclk = ~aclk;

    isolated_pixel_remover dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mask_value (s_mask_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_keep_pixel (m_keep_pixel),
        .m_frame_done (m_frame_done),
        .m_kept_count (m_kept_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ipr_result_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mask_value (s_mask_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_keep_pixel (m_keep_pixel),
        .m_frame_done (m_frame_done),
        .m_kept_count (m_kept_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .backlog      (backlog)
    );

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // end the run if no transfer of any kind happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [PIX_W-1:0] random_pixel(input int density);
        int mag;
        if ($urandom_range(0, 99) < density) begin
            return PIX_W'($urandom_range(1, 127));
        end
        mag = $urandom_range(0, 128);
        return PIX_W'(-mag);
    endfunction

    task automatic wait_drained();
        while (backlog != 0) @(negedge aclk);
    endtask

    task automatic send_pixel(input logic signed [PIX_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_mask_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // wait for the block to go idle, then write both size registers
    task automatic begin_frame(input logic [CFG_W-1:0] rows_val,
                               input logic [CFG_W-1:0] cols_val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= ipr_pkg::CFG_FRAME_ROWS;
        cfg_data  <= rows_val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_index <= ipr_pkg::CFG_FRAME_COLS;
        cfg_data  <= cols_val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_frame(input logic [CFG_W-1:0] rows_val,
                             input logic [CFG_W-1:0] cols_val,
                             input bit hold_midway, output int sent);
        int nr;
        int nc;
        int pause_at;
        int density;
        nr = (rows_val < 2) ? 2 : ((rows_val > MAX_ROWS) ? MAX_ROWS : rows_val);
        nc = (cols_val < 1) ? 1 : ((cols_val > MAX_COLS) ? MAX_COLS : cols_val);
        sent = nr * nc;
        pause_at = hold_midway ? $urandom_range(0, sent - 1) : -1;
        density = $urandom_range(15, 85);
        begin_frame(rows_val, cols_val);
        for (int k = 0; k < sent; k++) begin
            // hold the stream until every pending result is out
            if (k == pause_at) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                wait_drained();
            end
            send_pixel(random_pixel(density));
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        logic [CFG_W-1:0] rows_val;
        logic [CFG_W-1:0] cols_val;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single column, rows below range in both frames, cols in the second
        begin_frame(CFG_W'(0), CFG_W'(1));
        send_pixel(8'sd127);
        send_pixel(8'sd1);
        s_valid <= 1'b0;
        begin_frame(CFG_W'(1), CFG_W'(0));
        send_pixel(-8'sd128);
        send_pixel(8'sd5);
        s_valid <= 1'b0;
        begin_frame(CFG_W'(3), CFG_W'(4));
        foreach (pattern[i]) send_pixel(pattern[i]);
        s_valid <= 1'b0;

        // a frame with a full drain midway, then a wide frame with no idling
        run_frame(CFG_W'(6), CFG_W'(9), 1'b1, sent);
        steady <= 1'b1;
        run_frame(CFG_W'(3), CFG_W'(40), 1'b0, sent);
        steady <= 1'b0;

        while (random_sent < RANDOM_PIXELS) begin
            rows_val = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 1))
                                                   : CFG_W'($urandom_range(2, 7));
            cols_val = ($urandom_range(0, 9) == 0) ? CFG_W'(0)
                                                   : CFG_W'($urandom_range(1, 12));
            run_frame(rows_val, cols_val, $urandom_range(0, 3) == 0, sent);
            random_sent += sent;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && backlog == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
